// File: design/i2cmra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types and constants for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

   localparam int TICK_COUNT_WIDTH_DEFAULT = 16;
   localparam int PHASE_WIDTH              = 16;
   localparam logic [PHASE_WIDTH-1:0] PHASE_TICKS_RESET = 16'd2;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-3:0] REG_PHASE_TICKS = 1'b0;

   localparam int REQ_TDATA_WIDTH = 40;
   localparam int REQ_TUSER_WIDTH = 2;
   localparam int RSP_TDATA_WIDTH = 16;

   typedef struct packed {
      logic       request_valid;
      logic       operation;
      logic [7:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_value;
      logic [7:0] read_count;
      logic       sda_sample;
   } request_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_is_input;
      logic [7:0] read_byte;
      logic       read_byte_valid;
      logic       read_byte_last;
      logic       busy_res;
      logic       done_res;
      logic       status;
   } result_type;

endpackage
`default_nettype wire

// File: design/i2cmra_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master sequencer
// Holds the bus sequence state and advances it by one tick per transaction.
// ----------------------------------------------------------------------------
module i2cmra_core
   import i2cmra_pkg::*;
#(
   parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire request_type            req,
   input  wire logic [PHASE_WIDTH-1:0] phase_ticks,
   output result_type                  res
);

   localparam int CMP_WIDTH =
      ((TICK_COUNT_WIDTH > PHASE_WIDTH) ? TICK_COUNT_WIDTH : PHASE_WIDTH) + 1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_START_A, ST_START_B, ST_START_C,
      ST_W_SETUP, ST_W_HIGH, ST_W_LOW,
      ST_ACK_REL, ST_ACK_HIGH, ST_ACK_LOW,
      ST_R_REL, ST_R_HIGH, ST_R_LOW, ST_R_OUT,
      ST_M_SET, ST_M_HIGH, ST_M_LOW, ST_STOP
   } step_type;

   typedef struct packed {
      logic sda_in;
      logic sda;
      logic scl;
   } pins_type;

   typedef enum logic [1:0] {
      STAGE_DEVICE, STAGE_REGISTER, STAGE_VALUE, STAGE_READ
   } stage_type;

   step_type                     step_ff, step_in;
   logic [TICK_COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [2:0]                   bit_ff, bit_in;
   logic [7:0]                   shift_ff, shift_in;
   logic [7:0]                   left_ff, left_in;
   logic                         is_read_ff, is_read_in;
   logic [7:0]                   dev_ff, dev_in;
   logic [7:0]                   reg_ff, reg_in;
   logic [7:0]                   val_ff, val_in;
   pins_type                     pins_ff, pins_in;
   stage_type                    stage_ff, stage_in;
   logic                         nack_ff, nack_in;

   logic                         seg_end;
   logic [CMP_WIDTH-1:0]         count_ext;
   logic [CMP_WIDTH-1:0]         phase_ext;

   function automatic pins_type enter_pins(input step_type st, input logic [7:0] sh,
                                           input logic [2:0] bi, input logic [7:0] lf,
                                           input pins_type cur);
      logic     mack;
      pins_type p;
      mack = (lf == 8'd1);
      p    = cur;
      case (st)
         ST_START_A:  p = '{sda_in: 1'b0, sda: 1'b1, scl: 1'b1};
         ST_START_B:  p = '{sda_in: 1'b0, sda: 1'b0, scl: 1'b1};
         ST_START_C:  p = '{sda_in: 1'b0, sda: 1'b0, scl: 1'b0};
         ST_W_SETUP:  p = '{sda_in: 1'b0, sda: sh[7], scl: 1'b0};
         ST_W_HIGH:   p = '{sda_in: 1'b0, sda: sh[7], scl: 1'b1};
         ST_W_LOW:    p = '{sda_in: 1'b0, sda: (bi == 3'd7) | sh[7], scl: 1'b0};
         ST_ACK_REL:  p = '{sda_in: 1'b1, sda: 1'b1, scl: 1'b0};
         ST_ACK_HIGH: p = '{sda_in: 1'b1, sda: 1'b1, scl: 1'b1};
         ST_ACK_LOW:  p = '{sda_in: 1'b0, sda: 1'b1, scl: 1'b0};
         ST_R_REL:    p = '{sda_in: 1'b1, sda: 1'b1, scl: 1'b0};
         ST_R_HIGH:   p = '{sda_in: 1'b1, sda: 1'b1, scl: 1'b1};
         ST_R_LOW:    p = '{sda_in: 1'b1, sda: 1'b1, scl: 1'b0};
         ST_R_OUT:    p = '{sda_in: 1'b0, sda: 1'b1, scl: 1'b0};
         ST_M_SET:    p = '{sda_in: 1'b0, sda: mack, scl: 1'b0};
         ST_M_HIGH:   p = '{sda_in: 1'b0, sda: mack, scl: 1'b1};
         ST_M_LOW:    p = '{sda_in: 1'b0, sda: mack, scl: 1'b0};
         ST_STOP:     p = '{sda_in: 1'b0, sda: 1'b0, scl: 1'b1};
         default:     p = cur;
      endcase
      return p;
   endfunction

   always_comb begin
      step_in    = step_ff;
      count_in   = count_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      is_read_in = is_read_ff;
      dev_in     = dev_ff;
      reg_in     = reg_ff;
      val_in     = val_ff;
      pins_in    = pins_ff;
      stage_in   = stage_ff;
      nack_in    = nack_ff;
      res        = '0;
      count_ext  = '0;
      phase_ext  = CMP_WIDTH'(phase_ticks);
      seg_end    = 1'b0;

      if (step_in == ST_IDLE && req.request_valid) begin
         is_read_in = req.operation;
         dev_in     = req.device_address;
         reg_in     = req.register_address;
         val_in     = req.write_value;
         left_in    = (req.read_count == 8'd0) ? 8'd1 : req.read_count;
         stage_in   = STAGE_DEVICE;
         nack_in    = 1'b0;
         bit_in     = 3'd0;
         shift_in   = 8'd0;
         step_in    = ST_START_A;
         count_in   = '0;
         pins_in    = enter_pins(step_in, shift_in, bit_in, left_in, pins_in);
      end

      res.scl_level    = pins_in.scl;
      res.sda_level    = pins_in.sda;
      res.sda_is_input = pins_in.sda_in;

      if (step_in != ST_IDLE) begin
         res.busy_res = 1'b1;
         count_ext    = CMP_WIDTH'(count_in) + CMP_WIDTH'(1);
         seg_end      = (count_ext >= phase_ext) || (&count_in);
         if (!seg_end) begin
            count_in = count_in + TICK_COUNT_WIDTH'(1);
         end else begin
            count_in = '0;
            case (step_in)
               ST_START_A: step_in = ST_START_B;
               ST_START_B: step_in = ST_START_C;
               ST_START_C: begin
                  shift_in = (stage_in == STAGE_READ) ? (dev_in | 8'h01) : dev_in;
                  bit_in   = 3'd0;
                  step_in  = ST_W_SETUP;
               end
               ST_W_SETUP: step_in = ST_W_HIGH;
               ST_W_HIGH:  step_in = ST_W_LOW;
               ST_W_LOW: begin
                  shift_in = {shift_in[6:0], 1'b0};
                  if (bit_in == 3'd7) begin
                     bit_in  = 3'd0;
                     step_in = ST_ACK_REL;
                  end else begin
                     bit_in  = bit_in + 3'd1;
                     step_in = ST_W_SETUP;
                  end
               end
               ST_ACK_REL: step_in = ST_ACK_HIGH;
               ST_ACK_HIGH: begin
                  nack_in = req.sda_sample;
                  step_in = ST_ACK_LOW;
               end
               ST_ACK_LOW: begin
                  if (nack_in) begin
                     res.done_res = 1'b1;
                     res.status   = 1'b1;
                     step_in      = ST_IDLE;
                  end else begin
                     case (stage_in)
                        STAGE_DEVICE: begin
                           stage_in = STAGE_REGISTER;
                           shift_in = reg_in;
                           bit_in   = 3'd0;
                           step_in  = ST_W_SETUP;
                        end
                        STAGE_REGISTER: begin
                           if (is_read_in) begin
                              stage_in = STAGE_READ;
                              step_in  = ST_START_A;
                           end else begin
                              stage_in = STAGE_VALUE;
                              shift_in = val_in;
                              bit_in   = 3'd0;
                              step_in  = ST_W_SETUP;
                           end
                        end
                        STAGE_VALUE: step_in = ST_STOP;
                        default:     step_in = ST_R_REL;
                     endcase
                  end
               end
               ST_R_REL: begin
                  bit_in   = 3'd0;
                  shift_in = 8'd0;
                  step_in  = ST_R_HIGH;
               end
               ST_R_HIGH: begin
                  shift_in = {shift_in[6:0], req.sda_sample};
                  if (bit_in == 3'd7) begin
                     res.read_byte       = shift_in;
                     res.read_byte_valid = 1'b1;
                     res.read_byte_last  = (left_in == 8'd1);
                  end
                  step_in = ST_R_LOW;
               end
               ST_R_LOW: begin
                  if (bit_in == 3'd7) begin
                     step_in = ST_R_OUT;
                  end else begin
                     bit_in  = bit_in + 3'd1;
                     step_in = ST_R_HIGH;
                  end
               end
               ST_R_OUT:  step_in = ST_M_SET;
               ST_M_SET:  step_in = ST_M_HIGH;
               ST_M_HIGH: step_in = ST_M_LOW;
               ST_M_LOW: begin
                  if (left_in != 8'd0) begin
                     left_in = left_in - 8'd1;
                  end
                  step_in = (left_in == 8'd0) ? ST_STOP : ST_R_REL;
               end
               ST_STOP: begin
                  res.done_res = 1'b1;
                  pins_in      = '{sda_in: 1'b0, sda: 1'b1, scl: 1'b1};
                  step_in      = ST_IDLE;
               end
               default: step_in = ST_IDLE;
            endcase
            pins_in = enter_pins(step_in, shift_in, bit_in, left_in, pins_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ST_IDLE;
         count_ff   <= '0;
         bit_ff     <= 3'd0;
         shift_ff   <= 8'd0;
         left_ff    <= 8'd0;
         is_read_ff <= 1'b0;
         dev_ff     <= 8'd0;
         reg_ff     <= 8'd0;
         val_ff     <= 8'd0;
         pins_ff    <= '{sda_in: 1'b0, sda: 1'b1, scl: 1'b1};
         stage_ff   <= STAGE_DEVICE;
         nack_ff    <= 1'b0;
      end else if (step_en) begin
         step_ff    <= step_in;
         count_ff   <= count_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         left_ff    <= left_in;
         is_read_ff <= is_read_in;
         dev_ff     <= dev_in;
         reg_ff     <= reg_in;
         val_ff     <= val_in;
         pins_ff    <= pins_in;
         stage_ff   <= stage_in;
         nack_ff    <= nack_in;
      end
   end

endmodule
`default_nettype wire

// File: design/i2c_master_register_access.sv
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master register access
// Streaming I2C master that performs single register reads and writes.
// ----------------------------------------------------------------------------
// Each transaction on the req channel is one bus timing tick. It carries the
// sampled SDA level and, while the master is idle, an optional register read
// or write request. Every accepted tick yields exactly one transaction on the
// rsp channel with the pin drive for that tick, any received byte, and the
// busy, done and status flags. The phase_ticks register at address 0 sets
// the number of ticks in each delay step and is written over the APB port.
// The result of a tick is registered and presented on the
// cycle after acceptance. Throughput is one tick per cycle, set by the
// combinational sequencer update feeding the result register. While the
// receiver stalls, the pending result is held and a new tick is taken only
// in the cycle in which that result leaves. Reset empties the result
// register, returns the sequencer to idle with SCL and SDA released and
// restores phase_ticks to 2.
// ----------------------------------------------------------------------------
module i2c_master_register_access
   import i2cmra_pkg::*;
#(
   parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // device_address, register_address, write_value, read_count, sda_sample
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // request_valid, operation
   input  wire logic [REQ_TUSER_WIDTH-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // scl_level, sda_level, sda_is_input, read_byte, read_byte_valid,
   // busy_res, done_res, status
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata,
   // read_byte_last
   output logic                            rsp_tlast,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]       csr_prdata,
   output logic                            csr_pready
);

   logic [PHASE_WIDTH-1:0] phase_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff;
   result_type             step_res;
   request_type            req;
   logic                   accept;
   logic                   phase_sel;

   assign csr_pready = 1'b1;
   assign phase_sel  = (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_PHASE_TICKS);
   assign csr_prdata = phase_sel ? CSR_DATA_WIDTH'(phase_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_TICKS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && phase_sel) begin
         phase_ff <= csr_pwdata[PHASE_WIDTH-1:0];
      end
   end

   assign req.request_valid    = req_tuser[0];
   assign req.operation        = req_tuser[1];
   assign req.device_address   = req_tdata[7:0];
   assign req.register_address = req_tdata[15:8];
   assign req.write_value      = req_tdata[23:16];
   assign req.read_count       = req_tdata[31:24];
   assign req.sda_sample       = req_tdata[32];

   assign req_tready   = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   i2cmra_core #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept),
      .req         (req),
      .phase_ticks (phase_ff),
      .res         (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.read_byte_last;
   assign rsp_tdata  = {1'b0, rsp_ff.status, rsp_ff.done_res, rsp_ff.busy_res,
                        rsp_ff.read_byte_valid, rsp_ff.read_byte,
                        rsp_ff.sda_is_input, rsp_ff.sda_level, rsp_ff.scl_level};

endmodule
`default_nettype wire

// File: verif/i2c_master_register_access_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register access testbench
// Drives bus timing ticks into the master and checks each result against a
// cycle-by-tick prediction of the register write and read sequences.
// ----------------------------------------------------------------------------
module i2c_master_register_access_tb;
   import i2cmra_pkg::*;

   typedef enum logic [5:0] {
      SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_START_C,
      SEQ_BIT_SETUP, SEQ_BIT_HIGH, SEQ_BIT_LOW,
      SEQ_ACK_RELEASE, SEQ_ACK_HIGH, SEQ_ACK_LOW,
      SEQ_RX_RELEASE, SEQ_RX_HIGH, SEQ_RX_LOW, SEQ_RX_DONE,
      SEQ_MACK_SETUP, SEQ_MACK_HIGH, SEQ_MACK_LOW, SEQ_STOP
   } seq_type;

   typedef enum logic [1:0] {
      STAGE_DEVICE, STAGE_REGISTER, STAGE_DATA, STAGE_READ_DEVICE
   } stage_type;

   typedef struct packed {
      logic       start;
      logic       is_read;
      logic [7:0] dev;
      logic [7:0] reg_index;
      logic [7:0] data;
      logic [7:0] count;
      logic [3:0] nack_slot;
      logic       typed;
      result_type end_result;
   } row_type;

   localparam logic [CSR_ADDR_WIDTH-1:0] PHASE_ADDR = {REG_PHASE_TICKS, 2'b00};
   localparam longint unsigned COUNT_MAX = (64'd1 << TICK_COUNT_WIDTH_DEFAULT) - 1;

   localparam result_type IDLE_RELEASED = '{scl_level: 1'b1, sda_level: 1'b1, default: '0};
   localparam result_type IDLE_AFTER_NACK = '{sda_level: 1'b1, default: '0};
   localparam result_type END_STOP =
      '{scl_level: 1'b1, busy_res: 1'b1, done_res: 1'b1, default: '0};
   localparam result_type END_NACK =
      '{sda_level: 1'b1, busy_res: 1'b1, done_res: 1'b1, status: 1'b1, default: '0};

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic [REQ_TUSER_WIDTH-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   seq_type     seq_step = SEQ_IDLE;
   stage_type   stage = STAGE_DEVICE;
   int unsigned seg_count = 0;
   logic [2:0]  bit_pos = '0;
   logic [7:0]  shifter = '0;
   logic [7:0]  bytes_remaining = '0;
   logic        held_read = 1'b0;
   logic [7:0]  held_dev = '0;
   logic [7:0]  held_reg = '0;
   logic [7:0]  held_val = '0;
   logic        pin_scl = 1'b1;
   logic        pin_sda = 1'b1;
   logic        pin_in = 1'b0;
   logic        nack_seen = 1'b0;
   logic [15:0] phase_len = PHASE_TICKS_RESET;

   result_type  bus_results_due[$];
   int          error_count = 0;
   int          burst_left = 0;
   int          ready_mode = 0;
   int          ready_left = 0;
   row_type     plan [15];
   int unsigned phase_plan [4] = '{1, 3, 65535, 2};

   i2c_master_register_access u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic void set_pins(logic scl, logic sda, logic sda_in);
      pin_scl = scl;
      pin_sda = sda;
      pin_in = sda_in;
   endfunction

   function automatic void enter_step(seq_type next_step);
      logic msb;
      logic last_ack;
      msb = shifter[7];
      last_ack = (bytes_remaining == 8'd1);
      seq_step = next_step;
      seg_count = 0;
      case (next_step)
         SEQ_START_A:     set_pins(1'b1, 1'b1, 1'b0);
         SEQ_START_B:     set_pins(1'b1, 1'b0, 1'b0);
         SEQ_START_C:     set_pins(1'b0, 1'b0, 1'b0);
         SEQ_BIT_SETUP:   set_pins(1'b0, msb, 1'b0);
         SEQ_BIT_HIGH:    set_pins(1'b1, msb, 1'b0);
         SEQ_BIT_LOW:     set_pins(1'b0, (bit_pos == 3'd7) ? 1'b1 : msb, 1'b0);
         SEQ_ACK_RELEASE: set_pins(1'b0, 1'b1, 1'b1);
         SEQ_ACK_HIGH:    set_pins(1'b1, 1'b1, 1'b1);
         SEQ_ACK_LOW:     set_pins(1'b0, 1'b1, 1'b0);
         SEQ_RX_RELEASE:  set_pins(1'b0, 1'b1, 1'b1);
         SEQ_RX_HIGH:     set_pins(1'b1, 1'b1, 1'b1);
         SEQ_RX_LOW:      set_pins(1'b0, 1'b1, 1'b1);
         SEQ_RX_DONE:     set_pins(1'b0, 1'b1, 1'b0);
         SEQ_MACK_SETUP:  set_pins(1'b0, last_ack, 1'b0);
         SEQ_MACK_HIGH:   set_pins(1'b1, last_ack, 1'b0);
         SEQ_MACK_LOW:    set_pins(1'b0, last_ack, 1'b0);
         SEQ_STOP:        set_pins(1'b1, 1'b0, 1'b0);
         default:         seq_step = SEQ_IDLE;
      endcase
   endfunction

   function automatic void load_byte(logic [7:0] value);
      shifter = value;
      bit_pos = '0;
      enter_step(SEQ_BIT_SETUP);
   endfunction

   function automatic result_type bus_tick(request_type t);
      result_type r;
      int unsigned seg_len;
      r = '0;
      seg_len = (phase_len == 16'd0) ? 1 : phase_len;
      if (seq_step == SEQ_IDLE && t.request_valid) begin
         held_read = t.operation;
         held_dev = t.device_address;
         held_reg = t.register_address;
         held_val = t.write_value;
         bytes_remaining = (t.read_count == 8'd0) ? 8'd1 : t.read_count;
         stage = STAGE_DEVICE;
         nack_seen = 1'b0;
         bit_pos = '0;
         shifter = '0;
         enter_step(SEQ_START_A);
      end
      r.scl_level = pin_scl;
      r.sda_level = pin_sda;
      r.sda_is_input = pin_in;
      if (seq_step != SEQ_IDLE) begin
         r.busy_res = 1'b1;
         if (seg_count + 1 < seg_len && seg_count < COUNT_MAX) begin
            seg_count++;
         end else begin
            case (seq_step)
               SEQ_START_A: enter_step(SEQ_START_B);
               SEQ_START_B: enter_step(SEQ_START_C);
               SEQ_START_C: load_byte((stage == STAGE_READ_DEVICE) ? (held_dev | 8'h01) : held_dev);
               SEQ_BIT_SETUP: enter_step(SEQ_BIT_HIGH);
               SEQ_BIT_HIGH: enter_step(SEQ_BIT_LOW);
               SEQ_BIT_LOW: begin
                  shifter = shifter << 1;
                  if (bit_pos == 3'd7) begin
                     bit_pos = '0;
                     enter_step(SEQ_ACK_RELEASE);
                  end else begin
                     bit_pos++;
                     enter_step(SEQ_BIT_SETUP);
                  end
               end
               SEQ_ACK_RELEASE: enter_step(SEQ_ACK_HIGH);
               SEQ_ACK_HIGH: begin
                  nack_seen = t.sda_sample;
                  enter_step(SEQ_ACK_LOW);
               end
               SEQ_ACK_LOW: begin
                  if (nack_seen) begin
                     r.done_res = 1'b1;
                     r.status = 1'b1;
                     seq_step = SEQ_IDLE;
                     seg_count = 0;
                  end else begin
                     case (stage)
                        STAGE_DEVICE: begin
                           stage = STAGE_REGISTER;
                           load_byte(held_reg);
                        end
                        STAGE_REGISTER: begin
                           if (held_read) begin
                              stage = STAGE_READ_DEVICE;
                              enter_step(SEQ_START_A);
                           end else begin
                              stage = STAGE_DATA;
                              load_byte(held_val);
                           end
                        end
                        STAGE_DATA: enter_step(SEQ_STOP);
                        default: enter_step(SEQ_RX_RELEASE);
                     endcase
                  end
               end
               SEQ_RX_RELEASE: begin
                  bit_pos = '0;
                  shifter = '0;
                  enter_step(SEQ_RX_HIGH);
               end
               SEQ_RX_HIGH: begin
                  shifter = {shifter[6:0], t.sda_sample};
                  if (bit_pos == 3'd7) begin
                     r.read_byte = shifter;
                     r.read_byte_valid = 1'b1;
                     r.read_byte_last = (bytes_remaining == 8'd1);
                  end
                  enter_step(SEQ_RX_LOW);
               end
               SEQ_RX_LOW: begin
                  if (bit_pos == 3'd7) begin
                     enter_step(SEQ_RX_DONE);
                  end else begin
                     bit_pos++;
                     enter_step(SEQ_RX_HIGH);
                  end
               end
               SEQ_RX_DONE: enter_step(SEQ_MACK_SETUP);
               SEQ_MACK_SETUP: enter_step(SEQ_MACK_HIGH);
               SEQ_MACK_HIGH: enter_step(SEQ_MACK_LOW);
               SEQ_MACK_LOW: begin
                  if (bytes_remaining != 8'd0) bytes_remaining--;
                  if (bytes_remaining == 8'd0) enter_step(SEQ_STOP);
                  else enter_step(SEQ_RX_RELEASE);
               end
               SEQ_STOP: begin
                  r.done_res = 1'b1;
                  set_pins(1'b1, 1'b1, 1'b0);
                  seq_step = SEQ_IDLE;
                  seg_count = 0;
               end
               default: begin
                  seq_step = SEQ_IDLE;
                  seg_count = 0;
               end
            endcase
         end
      end
      return r;
   endfunction

   // The slave answers each address or data byte on the acknowledge slot
   // and, during a read, returns the given byte pattern when one is set.
   function automatic logic pick_sda(int nack_slot, int rx_pattern);
      if (seq_step == SEQ_ACK_HIGH) begin
         if (nack_slot < 0) return ($urandom_range(0, 99) < 3);
         return (int'(stage) + 1 == nack_slot);
      end
      if (seq_step == SEQ_RX_HIGH && rx_pattern >= 0) return rx_pattern[7 - bit_pos];
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic request_type random_tick(int req_pct, bit allow_read, int nack_slot,
                                               int rx_pattern);
      request_type t;
      t.request_valid = ($urandom_range(0, 99) < req_pct);
      t.operation = allow_read ? 1'($urandom_range(0, 1)) : 1'b0;
      t.device_address = 8'($urandom_range(0, 255));
      t.register_address = 8'($urandom_range(0, 255));
      t.write_value = 8'($urandom_range(0, 255));
      if (seq_step != SEQ_IDLE) t.read_count = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 9) < 8) t.read_count = 8'($urandom_range(0, 4));
      else t.read_count = 8'($urandom_range(5, 8));
      t.sda_sample = pick_sda(nack_slot, rx_pattern);
      return t;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
      if (want != seen) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
         error_count++;
      end
   endfunction

   function automatic void compare_result(result_type want, result_type seen);
      check_field("scl_level", 8'(want.scl_level), 8'(seen.scl_level));
      check_field("sda_level", 8'(want.sda_level), 8'(seen.sda_level));
      check_field("sda_is_input", 8'(want.sda_is_input), 8'(seen.sda_is_input));
      check_field("read_byte", want.read_byte, seen.read_byte);
      check_field("read_byte_valid", 8'(want.read_byte_valid), 8'(seen.read_byte_valid));
      check_field("read_byte_last", 8'(want.read_byte_last), 8'(seen.read_byte_last));
      check_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
      check_field("done_res", 8'(want.done_res), 8'(seen.done_res));
      check_field("status", 8'(want.status), 8'(seen.status));
   endfunction

   task automatic push_tick(request_type t, logic typed, result_type typed_res);
      result_type r;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(100, 300);
         end else begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, t.sda_sample, t.read_count, t.write_value, t.register_address,
                    t.device_address};
      req_tuser <= {t.operation, t.request_valid};
      do @(posedge clock); while (!req_tready);
      r = bus_tick(t);
      if (typed && seq_step == SEQ_IDLE) r = typed_res;
      bus_results_due.push_back(r);
   endtask

   task automatic finish_transfer(int nack_slot, int rx_pattern, logic typed,
                                  result_type end_result);
      while (seq_step != SEQ_IDLE)
         push_tick(random_tick(25, 1'b1, nack_slot, rx_pattern), typed, end_result);
   endtask

   task automatic run_random(int count, int req_pct, bit allow_read);
      repeat (count) push_tick(random_tick(req_pct, allow_read, -1, -1), 1'b0, '0);
      finish_transfer(-1, -1, 1'b0, '0);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (bus_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_transfer(logic wr, logic [CSR_DATA_WIDTH-1:0] wdata,
                               output logic [CSR_DATA_WIDTH-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= PHASE_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic check_phase_ticks(logic [CSR_DATA_WIDTH-1:0] want);
      logic [CSR_DATA_WIDTH-1:0] seen;
      csr_transfer(1'b0, '0, seen);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (seen !== want) begin
         $display("%0t: phase_ticks expected %0h, got %0h", $time, want, seen);
         error_count++;
      end
   endtask

   task automatic set_phase_ticks(int unsigned value);
      logic [CSR_DATA_WIDTH-1:0] unused;
      csr_transfer(1'b1, value, unused);
      phase_len = 16'(value);
      check_phase_ticks(value);
   endtask

   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = 200;
      end
      ready_left--;
      case (ready_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (ready_left % 4 == 0);
         default: rsp_tready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin : rsp_monitor
      result_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.scl_level = rsp_tdata[0];
         seen.sda_level = rsp_tdata[1];
         seen.sda_is_input = rsp_tdata[2];
         seen.read_byte = rsp_tdata[10:3];
         seen.read_byte_valid = rsp_tdata[11];
         seen.busy_res = rsp_tdata[12];
         seen.done_res = rsp_tdata[13];
         seen.status = rsp_tdata[14];
         seen.read_byte_last = rsp_tlast;
         if (bus_results_due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, got %h", $time, seen);
            error_count++;
         end else begin
            compare_result(bus_results_due.pop_front(), seen);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      rsp_tready <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      // Rows: start, read, device, register, data or read pattern, count,
      // acknowledge slot answered with NACK, typed end result.
      plan = '{
         '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0, 1'b1, IDLE_RELEASED},
         '{1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0, 1'b1, END_STOP},
         '{1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, 1'b1, END_STOP},
         '{1'b1, 1'b1, 8'hA0, 8'h10, 8'hFF, 8'h00, 4'd0, 1'b1, END_STOP},
         '{1'b1, 1'b1, 8'h01, 8'hFE, 8'h00, 8'h01, 4'd0, 1'b0, END_STOP},
         '{1'b1, 1'b1, 8'h3C, 8'h81, 8'h5A, 8'h03, 4'd0, 1'b0, END_STOP},
         '{1'b1, 1'b1, 8'hFF, 8'h00, 8'hA5, 8'h02, 4'd0, 1'b1, END_STOP},
         '{1'b1, 1'b0, 8'h50, 8'h20, 8'h77, 8'h00, 4'd1, 1'b1, END_NACK},
         '{1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, 1'b1, IDLE_AFTER_NACK},
         '{1'b1, 1'b0, 8'h50, 8'h21, 8'h78, 8'h00, 4'd2, 1'b1, END_NACK},
         '{1'b1, 1'b0, 8'h50, 8'h22, 8'h79, 8'h00, 4'd3, 1'b1, END_NACK},
         '{1'b1, 1'b1, 8'h51, 8'h23, 8'h00, 8'h02, 4'd2, 1'b1, END_NACK},
         '{1'b1, 1'b1, 8'h52, 8'h24, 8'h00, 8'h02, 4'd4, 1'b1, END_NACK},
         '{1'b1, 1'b0, 8'h6E, 8'h0F, 8'hC3, 8'h00, 4'd0, 1'b1, END_STOP},
         '{1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, 1'b1, IDLE_RELEASED}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_phase_ticks(CSR_DATA_WIDTH'(PHASE_TICKS_RESET));
      set_phase_ticks(0);

      foreach (plan[i]) begin
         request_type t;
         t.request_valid = plan[i].start;
         t.operation = plan[i].is_read;
         t.device_address = plan[i].dev;
         t.register_address = plan[i].reg_index;
         t.write_value = plan[i].data;
         t.read_count = plan[i].count;
         t.sda_sample = 1'($urandom_range(0, 1));
         push_tick(t, plan[i].typed, plan[i].end_result);
         finish_transfer(int'(plan[i].nack_slot), int'(plan[i].data), plan[i].typed,
                         plan[i].end_result);
      end
      drain_results();

      foreach (phase_plan[i]) begin
         set_phase_ticks(phase_plan[i]);
         if (phase_plan[i] == 3) run_random(1, 100, 1'b0);
         else if (phase_plan[i] == 65535) run_random(20, 0, 1'b1);
         else run_random(30, 70, 1'b1);
         drain_results();
      end

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/i2cmra_pkg.sv
design/i2cmra_core.sv
design/i2c_master_register_access.sv
verif/i2c_master_register_access_tb.sv
